@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

    localparam int DataW       = 32;
    localparam int FracBitsDef = 16;
    localparam int QuoW        = DataW + 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

endpackage

@@ hw/rtl/cau_in_if.sv @@
interface cau_in_if;

    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic signed [cau_pkg::DataW-1:0]  a_re;
    logic signed [cau_pkg::DataW-1:0]  a_im;
    logic signed [cau_pkg::DataW-1:0]  b_re;
    logic signed [cau_pkg::DataW-1:0]  b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);

endinterface

@@ hw/rtl/cau_out_if.sv @@
interface cau_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [cau_pkg::DataW-1:0]  res_re;
    logic signed [cau_pkg::DataW-1:0]  res_im;
    logic [1:0]                        status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);

endinterface

@@ hw/rtl/complex_arithmetic_unit_core.sv @@
// Channel  Dir  Payload                             Word accepted when
// req      in   req_type, a_re, a_im, b_re, b_im    req.valid && req.ready
// rsp      out  res_re, res_im, status              rsp.valid && rsp.ready
//
// One word enters per cycle while the pipeline is not held. There are 38 register stages
// (products, sums, operand setup, 34 restoring quotient stages, saturation). The quotient
// stages set the depth; all operations share the same latency. Reset clears the valid bits
// and the quotient stages. When the output word is not taken the whole pipeline holds, and
// req.ready drops for that cycle.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = cau_pkg::FracBitsDef
) (
    input logic       clk,
    input logic       rst_n,
    cau_in_if.sink    req,
    cau_out_if.source rsp
);

    localparam int DW = cau_pkg::DataW;
    localparam int PW = 2 * DW + 2;
    localparam int NW = PW + FRAC_BITS + 1;
    localparam int QW = cau_pkg::QuoW;
    localparam int RW = 2 * DW;
    localparam logic [NW-1:0] Half   = (NW'(1) << FRAC_BITS) >> 1;
    localparam logic [NW-1:0] LimPos = (NW'(1) << (DW - 1)) - NW'(1);
    localparam logic [NW-1:0] LimNeg = NW'(1) << (DW - 1);

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [NW-1:0] m;
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
    } part_t;

    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic          dz;
        logic [RW-1:0] den;
        part_t         re;
        part_t         im;
    } stg_t;

    logic advance;

    logic                   s1_valid_reg;
    cau_pkg::op_t           s1_op_reg;
    logic signed [RW-1:0]   s1_p_reg [0:5];
    logic signed [DW:0]     s1_as_re_reg;
    logic signed [DW:0]     s1_as_im_reg;

    logic                   s2_valid_reg;
    cau_pkg::op_t           s2_op_reg;
    logic signed [PW-1:0]   s2_sum_re_reg;
    logic signed [PW-1:0]   s2_sum_im_reg;
    logic [RW-1:0]          s2_den_reg;

    stg_t                   stg_reg [0:QW];
    stg_t                   stg_next [0:QW];

    logic                   out_valid_reg;
    logic signed [DW-1:0]   res_re_reg;
    logic signed [DW-1:0]   res_im_reg;
    logic [1:0]             status_reg;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= cau_pkg::op_t'(req.req_type);
            s1_p_reg[0] <= RW'(req.a_re) * RW'(req.b_re);
            s1_p_reg[1] <= RW'(req.a_im) * RW'(req.b_im);
            s1_p_reg[2] <= RW'(req.a_re) * RW'(req.b_im);
            s1_p_reg[3] <= RW'(req.a_im) * RW'(req.b_re);
            s1_p_reg[4] <= RW'(req.b_re) * RW'(req.b_re);
            s1_p_reg[5] <= RW'(req.b_im) * RW'(req.b_im);
            if (cau_pkg::op_t'(req.req_type) == cau_pkg::OP_SUB)
            begin
                s1_as_re_reg <= (DW + 1)'(req.a_re) - (DW + 1)'(req.b_re);
                s1_as_im_reg <= (DW + 1)'(req.a_im) - (DW + 1)'(req.b_im);
            end
            else
            begin
                s1_as_re_reg <= (DW + 1)'(req.a_re) + (DW + 1)'(req.b_re);
                s1_as_im_reg <= (DW + 1)'(req.a_im) + (DW + 1)'(req.b_im);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_den_reg <= $unsigned(s1_p_reg[4]) + $unsigned(s1_p_reg[5]);
            case (s1_op_reg)
                cau_pkg::OP_MUL:
                begin
                    s2_sum_re_reg <= PW'(s1_p_reg[0]) - PW'(s1_p_reg[1]);
                    s2_sum_im_reg <= PW'(s1_p_reg[2]) + PW'(s1_p_reg[3]);
                end
                cau_pkg::OP_DIV:
                begin
                    s2_sum_re_reg <= PW'(s1_p_reg[0]) + PW'(s1_p_reg[1]);
                    s2_sum_im_reg <= PW'(s1_p_reg[3]) - PW'(s1_p_reg[2]);
                end
                default:
                begin
                    s2_sum_re_reg <= PW'(s1_as_re_reg);
                    s2_sum_im_reg <= PW'(s1_as_im_reg);
                end
            endcase
        end
    end

    function automatic part_t setup_part(input logic signed [PW-1:0] sum,
                                         input cau_pkg::op_t op,
                                         input logic [RW-1:0] den);
        part_t         p;
        logic [PW-1:0] mag;
        logic [NW-1:0] top;
        p     = '0;
        p.neg = sum[PW-1];
        mag   = p.neg ? $unsigned(-sum) : $unsigned(sum);
        case (op)
            cau_pkg::OP_MUL: p.m = (NW'(mag) + Half) >> FRAC_BITS;
            cau_pkg::OP_DIV: p.m = NW'(mag) << (FRAC_BITS + 1);
            default:         p.m = NW'(mag);
        endcase
        top   = p.m >> QW;
        p.ovf = top >= NW'(den);
        p.rem = top[RW-1:0];
        return p;
    endfunction

    always_comb
    begin
        stg_next[0].valid  = s2_valid_reg;
        stg_next[0].is_div = s2_op_reg == cau_pkg::OP_DIV;
        stg_next[0].dz     = s2_den_reg == '0;
        stg_next[0].den    = s2_den_reg;
        stg_next[0].re     = setup_part(s2_sum_re_reg, s2_op_reg, s2_den_reg);
        stg_next[0].im     = setup_part(s2_sum_im_reg, s2_op_reg, s2_den_reg);
    end

    function automatic part_t div_step(input part_t p, input logic [RW-1:0] den,
                                       input logic nbit);
        part_t       r;
        logic [RW:0] t;
        r = p;
        t = {p.rem, nbit};
        if (t >= {1'b0, den})
        begin
            r.rem = RW'(t - {1'b0, den});
            r.q   = {p.q[QW-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[RW-1:0];
            r.q   = {p.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        always_comb
        begin
            stg_next[k+1]    = stg_reg[k];
            stg_next[k+1].re = div_step(stg_reg[k].re, stg_reg[k].den,
                                        stg_reg[k].re.m[QW-1-k]);
            stg_next[k+1].im = div_step(stg_reg[k].im, stg_reg[k].den,
                                        stg_reg[k].im.m[QW-1-k]);
        end
    end

    for (genvar k = 0; k <= QW; k++)
    begin : g_stg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_reg[k] <= '0;
            end
            else if (advance)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    function automatic logic [DW:0] finish_part(input part_t p, input logic is_div);
        logic [QW:0]   qr;
        logic [NW-1:0] mag;
        logic [NW-1:0] lim;
        logic          sat;
        logic [DW-1:0] v;
        qr  = ({1'b0, p.q} + (QW + 1)'(1)) >> 1;
        mag = is_div ? NW'(qr) : p.m;
        lim = p.neg ? LimNeg : LimPos;
        sat = (is_div && p.ovf) || (mag > lim);
        v   = sat ? lim[DW-1:0] : mag[DW-1:0];
        return {sat, p.neg ? -v : v};
    endfunction

    logic [DW:0] fin_re;
    logic [DW:0] fin_im;

    assign fin_re = finish_part(stg_reg[QW].re, stg_reg[QW].is_div);
    assign fin_im = finish_part(stg_reg[QW].im, stg_reg[QW].is_div);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_reg[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (stg_reg[QW].is_div && stg_reg[QW].dz)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                status_reg <= cau_pkg::ST_DIV0;
            end
            else
            begin
                res_re_reg <= fin_re[DW-1:0];
                res_im_reg <= fin_im[DW-1:0];
                status_reg <= (fin_re[DW] || fin_im[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.res_re = res_re_reg;
    assign rsp.res_im = res_im_reg;
    assign rsp.status = status_reg;

endmodule

@@ hw/rtl/cau_checker.sv @@
module cau_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [cau_pkg::DataW-1:0] res_re,
    input logic [cau_pkg::DataW-1:0] res_im,
    input logic [1:0]                status
);

    localparam logic [cau_pkg::DataW-1:0] MaxPos = {1'b0, {(cau_pkg::DataW - 1){1'b1}}};
    localparam logic [cau_pkg::DataW-1:0] MaxNeg = {1'b1, {(cau_pkg::DataW - 1){1'b0}}};

    a_no_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status != cau_pkg::ST_RSVD)
        else $error("reserved status code on a result word");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == cau_pkg::ST_DIV0) |-> (res_re == '0 && res_im == '0))
        else $error("division by zero word carries a nonzero result");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == cau_pkg::ST_SAT) |->
            (res_re == MaxPos || res_re == MaxNeg || res_im == MaxPos || res_im == MaxNeg))
        else $error("saturated word has no clamped part");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(res_re) && $stable(res_im) && $stable(status)))
        else $error("stalled result word changed");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_re    (rsp.res_re),
    .res_im    (rsp.res_im),
    .status    (rsp.status)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        cau_pkg::op_t       op;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        cau_pkg::status_t   st;
    } rsp_word_t;

    localparam int Latency = 38;
    localparam int CycleLimit = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    cau_in_if  req();
    cau_out_if rsp();

    complex_arithmetic_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    req_word_t pending_q[$];
    rsp_word_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit hold_sender = 1'b0;
    bit hold_receiver = 1'b0;
    int hold_cycles = 0;
    bit stim_done = 1'b0;

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v, ref bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Round to nearest with ties away from zero, after dropping 16 bits.
    function automatic logic signed [127:0] round_q16(input logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + (128'd1 << 15)) >> 16;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [127:0] div_round(input logic signed [127:0] n,
                                                      input logic [127:0] d);
        logic [127:0] m;
        m = n < 0 ? -n : n;
        m = (((m << 17) / d) + 128'd1) >> 1;
        return n < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic rsp_word_t compute_complex(input req_word_t w);
        logic signed [127:0] ar, ai, br, bi, rr, ri;
        logic [127:0] den;
        rsp_word_t r;
        bit sat;
        ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
        sat = 1'b0;
        case (w.op)
            cau_pkg::OP_ADD:
            begin
                rr = ar + br; ri = ai + bi;
            end
            cau_pkg::OP_SUB:
            begin
                rr = ar - br; ri = ai - bi;
            end
            cau_pkg::OP_MUL:
            begin
                rr = round_q16(ar * br - ai * bi);
                ri = round_q16(ar * bi + ai * br);
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.re = '0; r.im = '0; r.st = cau_pkg::ST_DIV0;
                    return r;
                end
                rr = div_round(ar * br + ai * bi, den);
                ri = div_round(ai * br - ar * bi, den);
            end
        endcase
        r.re = clamp(rr, sat);
        r.im = clamp(ri, sat);
        r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4, 5: return $signed(16'($urandom)) <<< $urandom_range(0, 16);
            6: return 32'($signed(8'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic push_word(input cau_pkg::op_t op, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        pending_q.push_back({op, ar, ai, br, bi});
    endtask

    initial
    begin
        req_word_t w;
        logic [31:0] mn, mx;
        cau_pkg::op_t ops[4];
        mn = 32'h80000000;
        mx = 32'h7fffffff;
        ops = '{cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_DIV};
        foreach (ops[i])
        begin
            push_word(ops[i], mx, mx, mx, mx);
            push_word(ops[i], mn, mn, mn, mn);
            push_word(ops[i], mn, mx, mx, mn);
        end
        push_word(cau_pkg::OP_DIV, 32'h00010000, 32'h5, 32'h0, 32'h0);
        push_word(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(cau_pkg::OP_DIV, 32'h00030000, 32'h0, 32'h00020000, 32'h0);
        push_word(cau_pkg::OP_DIV, 32'h1, 32'h0, 32'h2, 32'h0);
        push_word(cau_pkg::OP_DIV, 32'hffffffff, 32'h0, 32'h2, 32'h0);
        push_word(cau_pkg::OP_MUL, 32'h00008000, 32'h0, 32'h1, 32'h0);
        push_word(cau_pkg::OP_MUL, 32'hffff8000, 32'h0, 32'h1, 32'h0);
        push_word(cau_pkg::OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hffff0000);
        push_word(cau_pkg::OP_DIV, 32'h1, 32'h1, 32'h1, 32'h0);
        for (int i = 0; i < 700; i++)
        begin
            w.op = cau_pkg::op_t'($urandom_range(0, 3));
            w.a_re = rand_operand(); w.a_im = rand_operand();
            w.b_re = rand_operand(); w.b_im = rand_operand();
            pending_q.push_back(w);
            if (i == 250)
            begin
                hold_receiver = 1'b1;
                wait (hold_cycles >= 150);
                hold_receiver = 1'b0;
            end
            if (i == 500)
            begin
                wait (pending_q.size() == 0);
                hold_sender = 1'b1;
                wait (!req.valid && expected_q.size() == 0);
                hold_sender = 1'b0;
            end
        end
        wait (pending_q.size() == 0 && !req.valid);
        stim_done = 1'b1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_receiver)
            hold_cycles <= hold_cycles + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.req_type <= '0;
            req.a_re <= '0;
            req.a_im <= '0;
            req.b_re <= '0;
            req.b_im <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_q.push_back(compute_complex(
                    {cau_pkg::op_t'(req.req_type), req.a_re, req.a_im, req.b_re, req.b_im}));
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_q.size() > 0 && !hold_sender)
                begin
                    {req.req_type, req.a_re, req.a_im, req.b_re, req.b_im}
                        <= pending_q.pop_front();
                    req.valid <= 1'b1;
                    send_gap <= rand_gap();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t exp_w;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("Unexpected word: re=%h im=%h st=%0d",
                                 rsp.res_re, rsp.res_im, rsp.status);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (rsp.res_re !== exp_w.re || rsp.res_im !== exp_w.im
                        || rsp.status !== exp_w.st)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("Mismatch: exp re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                                     exp_w.re, exp_w.im, exp_w.st,
                                     rsp.res_re, rsp.res_im, rsp.status);
                    end
                end
            end
            if (hold_receiver)
                rsp.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                recv_gap <= rand_gap();
            end
        end
    end

    initial
    begin
        wait (stim_done && expected_q.size() == 0);
        repeat (Latency + 10) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
